FILE: design/rdop_pkg.sv
`default_nettype none
package rdop_pkg;

    localparam int HEADER_BYTES = 16;

    localparam logic [7:0] TYPE_SERVER = 8'd25;
    localparam logic [7:0] TYPE_SEARCH = 8'd31;
    localparam int UNIT_SHIFT = 3;

    localparam logic [2:0] KIND_SERVER = 3'd0;
    localparam logic [2:0] KIND_CHAR   = 3'd1;
    localparam logic [2:0] KIND_END    = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [1:0] PHASE_BEFORE = 2'd0;
    localparam logic [1:0] PHASE_IN     = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] lifetime;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  name_char;
        logic        last_in_run;
    } out_beat_t;

    typedef struct packed {
        logic [4:0]   header_count;
        logic [10:0]  option_offset;
        logic [7:0]   option_type;
        logic [10:0]  option_bytes_left;
        logic [31:0]  lifetime_shift;
        logic [127:0] address_shift;
        logic [7:0]   label_bytes_left;
        logic [1:0]   name_phase;
        logic         error_seen;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] count;
        out_beat_t  first;
        out_beat_t  second;
    } step_results_t;

endpackage
`default_nettype wire

FILE: design/rdop_step.sv
`default_nettype none
module rdop_step (
    input  wire rdop_pkg::parse_state_t  state,
    input  wire rdop_pkg::in_beat_t      beat,
    output rdop_pkg::parse_state_t       state_next,
    output rdop_pkg::step_results_t      results
);

    localparam logic [10:0] LIFE_FIRST = 11'd4;
    localparam logic [10:0] LIFE_LAST  = 11'd7;
    localparam logic [10:0] ADDR_FIRST = 11'd8;
    localparam logic [10:0] ADDR_LAST  = 11'd23;
    localparam logic [10:0] NAME_FIRST = 11'd8;
    localparam logic [7:0]  DOT_CHAR   = 8'h2E;

    rdop_pkg::out_beat_t opt_item;
    rdop_pkg::out_beat_t end_item;
    logic                opt_valid;
    logic                end_valid;
    logic [7:0]          b;
    logic [10:0]         left_dec;

    always_comb begin
        state_next = state;
        opt_item   = '0;
        end_item   = '0;
        opt_valid  = 1'b0;
        end_valid  = 1'b0;
        b          = beat.data_byte;
        left_dec   = state.option_bytes_left - 11'd1;

        if (!state.error_seen) begin
            if (state.header_count < 5'(rdop_pkg::HEADER_BYTES)) begin
                state_next.header_count = state.header_count + 5'd1;
            end else if (state.option_offset == 11'd0) begin
                state_next.option_type      = b;
                state_next.name_phase       = rdop_pkg::PHASE_BEFORE;
                state_next.label_bytes_left = '0;
                state_next.option_offset    = 11'd1;
            end else if (state.option_offset == 11'd1) begin
                if (b == 8'd0) begin
                    opt_valid             = 1'b1;
                    opt_item.kind         = rdop_pkg::KIND_ERROR;
                    state_next.error_seen = 1'b1;
                end else begin
                    state_next.option_bytes_left =
                        {b, {rdop_pkg::UNIT_SHIFT{1'b0}}} - 11'd2;
                    state_next.option_offset = 11'd2;
                end
            end else begin
                if (state.option_type == rdop_pkg::TYPE_SERVER) begin
                    if (state.option_offset >= LIFE_FIRST && state.option_offset <= LIFE_LAST) begin
                        state_next.lifetime_shift = {state.lifetime_shift[23:0], b};
                    end
                    if (state.option_offset >= ADDR_FIRST && state.option_offset <= ADDR_LAST) begin
                        state_next.address_shift = {state.address_shift[119:0], b};
                        if (state.option_offset == ADDR_LAST) begin
                            opt_valid             = 1'b1;
                            opt_item.kind         = rdop_pkg::KIND_SERVER;
                            opt_item.lifetime     = state.lifetime_shift;
                            opt_item.address_high = state_next.address_shift[127:64];
                            opt_item.address_low  = state_next.address_shift[63:0];
                        end
                    end
                end else if (state.option_type == rdop_pkg::TYPE_SEARCH
                             && state.option_offset >= NAME_FIRST
                             && state.name_phase != rdop_pkg::PHASE_DONE) begin
                    if (state.label_bytes_left != 8'd0) begin
                        opt_valid                   = 1'b1;
                        opt_item.kind               = rdop_pkg::KIND_CHAR;
                        opt_item.name_char          = b;
                        state_next.label_bytes_left = state.label_bytes_left - 8'd1;
                    end else if (b == 8'd0) begin
                        opt_valid             = 1'b1;
                        opt_item.kind         = rdop_pkg::KIND_END;
                        state_next.name_phase = rdop_pkg::PHASE_DONE;
                    end else begin
                        if (state.name_phase == rdop_pkg::PHASE_IN) begin
                            opt_valid          = 1'b1;
                            opt_item.kind      = rdop_pkg::KIND_CHAR;
                            opt_item.name_char = DOT_CHAR;
                        end
                        state_next.name_phase       = rdop_pkg::PHASE_IN;
                        state_next.label_bytes_left = b;
                    end
                end
                state_next.option_bytes_left = left_dec;
                state_next.option_offset     = state.option_offset + 11'd1;
                if (left_dec == 11'd0) begin
                    state_next.option_offset = 11'd0;
                end
            end

            if (beat.last_byte && !state_next.error_seen) begin
                end_valid     = 1'b1;
                end_item.kind = (state_next.option_offset == 11'd0) ?
                                rdop_pkg::KIND_DONE : rdop_pkg::KIND_ERROR;
            end
        end

        if (beat.last_byte) begin
            state_next.header_count      = '0;
            state_next.option_offset     = '0;
            state_next.option_type       = '0;
            state_next.option_bytes_left = '0;
            state_next.label_bytes_left  = '0;
            state_next.name_phase        = rdop_pkg::PHASE_BEFORE;
            state_next.error_seen        = 1'b0;
        end
    end

    always_comb begin
        results = '0;
        if (opt_valid && end_valid) begin
            results.count              = 2'd2;
            results.first              = opt_item;
            results.second             = end_item;
            results.second.last_in_run = 1'b1;
        end else if (opt_valid) begin
            results.count             = 2'd1;
            results.first             = opt_item;
            results.first.last_in_run = 1'b1;
        end else if (end_valid) begin
            results.count             = 2'd1;
            results.first             = end_item;
            results.first.last_in_run = 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: design/rdop_result_queue.sv
`default_nettype none
module rdop_result_queue (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire rdop_pkg::step_results_t push,
    output logic                         has_room,
    output logic                         m_valid,
    input  wire                          m_ready,
    output rdop_pkg::out_beat_t          m_data
);

    rdop_pkg::out_beat_t               entries [rdop_pkg::QUEUE_DEPTH];
    logic [rdop_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [rdop_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [rdop_pkg::QCNT_W-1:0]       count_reg;
    logic [rdop_pkg::QPTR_W-1:0]       wr_ptr_inc;
    logic                              pop;

    assign wr_ptr_inc = wr_ptr_reg + rdop_pkg::QPTR_W'(1);
    assign pop        = m_valid && m_ready;
    assign m_valid    = (count_reg != '0);
    assign m_data     = entries[rd_ptr_reg];
    assign has_room   = (count_reg <= rdop_pkg::QCNT_W'(rdop_pkg::QUEUE_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + rdop_pkg::QPTR_W'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rdop_pkg::QPTR_W'(1);
            end
            count_reg <= count_reg + rdop_pkg::QCNT_W'(push.count)
                         - rdop_pkg::QCNT_W'(pop);
        end
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn)
            count_reg <= rdop_pkg::QCNT_W'(rdop_pkg::QUEUE_DEPTH);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("result queue overflow");

    property p_push_needs_room;
        @(posedge aclk) disable iff (!aresetn)
            (push.count == 2'd2) |-> (count_reg <= rdop_pkg::QCNT_W'(rdop_pkg::QUEUE_DEPTH - 2));
    endproperty
    a_push_needs_room: assert property (p_push_needs_room) else $error("push without room");

endmodule
`default_nettype wire

FILE: design/ra_dns_option_parser.sv
// Router advertisement DNS option parser. Takes one packet byte per beat on s_
// and reports server options (lifetime and first address), search list name
// characters, name end and packet done or error as result beats on m_. A byte
// is accepted every cycle while the four-entry result queue has room for two
// results; a byte that yields two results (a result plus the packet end) is
// sent as two result beats on m_, so the sustained rate is one byte per cycle
// whenever m_ready keeps up. Results pass through the registered result queue.
`default_nettype none
module ra_dns_option_parser (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire rdop_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output rdop_pkg::out_beat_t      m_data
);

    rdop_pkg::parse_state_t  state_reg;
    rdop_pkg::parse_state_t  state_next;
    rdop_pkg::step_results_t step_res;
    rdop_pkg::step_results_t push;
    logic                    accept;

    assign accept = s_valid && s_ready;

    rdop_step u_step (
        .state      (state_reg),
        .beat       (s_data),
        .state_next (state_next),
        .results    (step_res)
    );

    always_comb begin
        push = step_res;
        if (!accept) begin
            push.count = 2'd0;
        end
    end

    rdop_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .has_room (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    property p_error_silent;
        @(posedge aclk) disable iff (!aresetn)
            (accept && state_reg.error_seen) |-> (step_res.count == 2'd0);
    endproperty
    a_error_silent: assert property (p_error_silent) else $error("result after packet error");

    property p_last_clears;
        @(posedge aclk) disable iff (!aresetn)
            (accept && s_data.last_byte) |=>
                (state_reg.header_count == '0 && state_reg.option_offset == '0
                 && !state_reg.error_seen);
    endproperty
    a_last_clears: assert property (p_last_clears) else $error("packet state not cleared");

    property p_last_ends_run;
        @(posedge aclk) disable iff (!aresetn)
            (accept && s_data.last_byte && !state_reg.error_seen) |->
                (step_res.count != 2'd0);
    endproperty
    a_last_ends_run: assert property (p_last_ends_run) else $error("packet end not reported");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    rdop_pkg::in_beat_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    rdop_pkg::out_beat_t m_data;

    ra_dns_option_parser u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    rdop_pkg::in_beat_t  byte_queue[$];
    rdop_pkg::out_beat_t expected_reports[$];
    logic [7:0]          pkt_bytes[$];
    logic [7:0]          name_text[$];

    int   bytes_sent  = 0;
    int   stall_at    = 1000000000;
    int   hold_cycles = 0;
    logic stall_done  = 1'b0;
    int   mismatches  = 0;
    logic burst;

    assign burst = (bytes_sent >= stall_at - 60) && (bytes_sent < stall_at + 100);

    // shadow of the parser state
    logic [4:0]  hdr_cnt;
    logic [10:0] opt_pos;
    logic [7:0]  opt_kind;
    logic [10:0] opt_left;
    logic [31:0] life_acc;
    logic [63:0] addr_hi_acc;
    logic [63:0] addr_lo_acc;
    logic [7:0]  label_left;
    logic [1:0]  phase;
    logic        bad_pkt;

    task automatic clear_packet_state();
        hdr_cnt    = '0;
        opt_pos    = '0;
        opt_kind   = '0;
        opt_left   = '0;
        label_left = '0;
        phase      = rdop_pkg::PHASE_BEFORE;
        bad_pkt    = 1'b0;
    endtask

    task automatic reset_tracker();
        clear_packet_state();
        life_acc    = '0;
        addr_hi_acc = '0;
        addr_lo_acc = '0;
    endtask

    function automatic rdop_pkg::out_beat_t make_report(input logic [2:0] kind,
                                                        input logic [7:0] ch);
        rdop_pkg::out_beat_t r;
        r = '0;
        r.kind = kind;
        r.name_char = ch;
        return r;
    endfunction

    task automatic track_byte(input rdop_pkg::in_beat_t beat);
        rdop_pkg::out_beat_t step_out [0:1];
        int                  n;
        logic                failed;
        logic [7:0]          b;
        n = 0;
        failed = 1'b0;
        b = beat.data_byte;
        if (bad_pkt) begin
            if (beat.last_byte)
                clear_packet_state();
            return;
        end
        if (hdr_cnt < rdop_pkg::HEADER_BYTES) begin
            hdr_cnt = hdr_cnt + 5'd1;
        end else if (opt_pos == 0) begin
            opt_kind = b;
            phase = rdop_pkg::PHASE_BEFORE;
            label_left = '0;
            opt_pos = 11'd1;
        end else if (opt_pos == 1) begin
            if (b == 0) begin
                step_out[n] = make_report(rdop_pkg::KIND_ERROR, 8'd0);
                n++;
                failed = 1'b1;
                bad_pkt = 1'b1;
            end else begin
                opt_left = {b, 3'b000} - 11'd2;
                opt_pos = 11'd2;
            end
        end else begin
            if (opt_kind == rdop_pkg::TYPE_SERVER) begin
                if (opt_pos >= 4 && opt_pos <= 7)
                    life_acc = {life_acc[23:0], b};
                if (opt_pos >= 8 && opt_pos <= 23) begin
                    addr_hi_acc = {addr_hi_acc[55:0], addr_lo_acc[63:56]};
                    addr_lo_acc = {addr_lo_acc[55:0], b};
                    if (opt_pos == 23) begin
                        step_out[n] = make_report(rdop_pkg::KIND_SERVER, 8'd0);
                        step_out[n].lifetime = life_acc;
                        step_out[n].address_high = addr_hi_acc;
                        step_out[n].address_low = addr_lo_acc;
                        n++;
                    end
                end
            end else if (opt_kind == rdop_pkg::TYPE_SEARCH && opt_pos >= 8
                         && phase != rdop_pkg::PHASE_DONE) begin
                if (label_left != 0) begin
                    step_out[n] = make_report(rdop_pkg::KIND_CHAR, b);
                    n++;
                    label_left = label_left - 8'd1;
                end else if (b == 0) begin
                    step_out[n] = make_report(rdop_pkg::KIND_END, 8'd0);
                    n++;
                    phase = rdop_pkg::PHASE_DONE;
                end else begin
                    if (phase == rdop_pkg::PHASE_IN) begin
                        step_out[n] = make_report(rdop_pkg::KIND_CHAR, 8'h2E);
                        n++;
                    end
                    phase = rdop_pkg::PHASE_IN;
                    label_left = b;
                end
            end
            opt_left = opt_left - 11'd1;
            opt_pos = opt_pos + 11'd1;
            if (opt_left == 0)
                opt_pos = '0;
        end
        if (beat.last_byte) begin
            if (!failed) begin
                step_out[n] = make_report(opt_pos == 0 ? rdop_pkg::KIND_DONE
                                                       : rdop_pkg::KIND_ERROR, 8'd0);
                n++;
            end
            clear_packet_state();
        end
        if (n > 0)
            step_out[n - 1].last_in_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_reports.push_back(step_out[i]);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            bytes_sent <= 0;
            reset_tracker();
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                track_byte(s_data);
                bytes_sent <= bytes_sent + 1;
            end
            if (byte_queue.size() != 0 && (burst || $urandom_range(0, 99) >= 17)) begin
                s_valid <= 1'b1;
                s_data <= byte_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off once the burst is running
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cycles <= 0;
            stall_done <= 1'b0;
        end else if (hold_cycles != 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!stall_done && bytes_sent >= stall_at) begin
            m_ready <= 1'b0;
            hold_cycles <= 120;
            stall_done <= 1'b1;
        end else begin
            m_ready <= burst || ($urandom_range(0, 99) >= 17);
        end
    end

    rdop_pkg::out_beat_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %h", $time, m_data);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (m_data.kind !== want.kind) begin
                    $display("%0t: kind expected %0d got %0d", $time, want.kind, m_data.kind);
                    mismatches++;
                end
                if (m_data.lifetime !== want.lifetime) begin
                    $display("%0t: lifetime expected %h got %h",
                             $time, want.lifetime, m_data.lifetime);
                    mismatches++;
                end
                if (m_data.address_high !== want.address_high) begin
                    $display("%0t: address_high expected %h got %h",
                             $time, want.address_high, m_data.address_high);
                    mismatches++;
                end
                if (m_data.address_low !== want.address_low) begin
                    $display("%0t: address_low expected %h got %h",
                             $time, want.address_low, m_data.address_low);
                    mismatches++;
                end
                if (m_data.name_char !== want.name_char) begin
                    $display("%0t: name_char expected %h got %h",
                             $time, want.name_char, m_data.name_char);
                    mismatches++;
                end
                if (m_data.last_in_run !== want.last_in_run) begin
                    $display("%0t: last_in_run expected %b got %b",
                             $time, want.last_in_run, m_data.last_in_run);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic start_packet();
        pkt_bytes = {};
        repeat (rdop_pkg::HEADER_BYTES) pkt_bytes.push_back(rand_byte());
    endtask

    task automatic add_server(input int units, input logic [31:0] life,
                              input logic [127:0] addr);
        logic [7:0] b;
        for (int i = 0; i < units * 8; i++) begin
            if (i == 0)
                b = rdop_pkg::TYPE_SERVER;
            else if (i == 1)
                b = units[7:0];
            else if (i >= 4 && i <= 7)
                b = life[8 * (7 - i) +: 8];
            else if (i >= 8 && i <= 23)
                b = addr[8 * (23 - i) +: 8];
            else
                b = rand_byte();
            pkt_bytes.push_back(b);
        end
    endtask

    task automatic add_search(input int units);
        logic [7:0] b;
        for (int i = 0; i < units * 8; i++) begin
            if (i == 0)
                b = rdop_pkg::TYPE_SEARCH;
            else if (i == 1)
                b = units[7:0];
            else if (i >= 8 && i - 8 < name_text.size())
                b = name_text[i - 8];
            else
                b = rand_byte();
            pkt_bytes.push_back(b);
        end
    endtask

    task automatic add_other(input logic [7:0] kind, input int units);
        pkt_bytes.push_back(kind);
        pkt_bytes.push_back(units[7:0]);
        repeat (units * 8 - 2) pkt_bytes.push_back(rand_byte());
    endtask

    task automatic add_zero_length();
        pkt_bytes.push_back(rand_byte());
        pkt_bytes.push_back(8'd0);
        repeat ($urandom_range(0, 6)) pkt_bytes.push_back(rand_byte());
    endtask

    task automatic add_label(input int len);
        name_text.push_back(len[7:0]);
        repeat (len) name_text.push_back(rand_byte());
    endtask

    task automatic random_name();
        name_text = {};
        repeat ($urandom_range(1, 3)) add_label($urandom_range(1, 6));
        if ($urandom_range(0, 9) != 0)
            name_text.push_back(8'd0);
        if ($urandom_range(0, 2) == 0) begin
            add_label($urandom_range(1, 4));
            name_text.push_back(8'd0);
        end
    endtask

    task automatic send_packet(input int keep);
        rdop_pkg::in_beat_t beat;
        for (int i = 0; i < keep; i++) begin
            beat.data_byte = pkt_bytes[i];
            beat.last_byte = (i == keep - 1);
            byte_queue.push_back(beat);
        end
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int units;
        int roll;
        int random_base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // servers at both extremes, a short server option, unknown types
        start_packet();
        add_server(3, 32'hFFFF_FFFF, '1);
        add_server(3, 32'h0, '0);
        add_server(2, 32'h1234_5678, {4{32'hA5C3_0F96}});
        add_other(8'h00, 1);
        add_other(8'hFF, 2);
        send_packet(pkt_bytes.size());

        // dotted name followed by a second name that must be ignored
        start_packet();
        name_text = {};
        add_label(3);
        add_label(1);
        name_text.push_back(8'd0);
        add_label(2);
        name_text.push_back(8'd0);
        add_search(3);
        send_packet(pkt_bytes.size());

        // name cut by option end, then a maximum-length label
        start_packet();
        name_text = {};
        add_label(20);
        add_search(2);
        name_text = {};
        add_label(255);
        name_text.push_back(8'd0);
        add_search(34);
        send_packet(pkt_bytes.size());

        start_packet();
        add_server(3, $urandom, {$urandom, $urandom, $urandom, $urandom});
        add_zero_length();
        send_packet(pkt_bytes.size());

        start_packet();
        add_server(3, $urandom, {$urandom, $urandom, $urandom, $urandom});
        send_packet(pkt_bytes.size() - 5);

        start_packet();
        send_packet(5);
        start_packet();
        send_packet(1);

        start_packet();
        pkt_bytes.push_back(rdop_pkg::TYPE_SERVER);
        send_packet(pkt_bytes.size());

        // longest option length, cut short
        start_packet();
        add_other(8'h80, 255);
        send_packet(rdop_pkg::HEADER_BYTES + 12);

        wait_drained();

        stall_at = bytes_sent + 70;
        random_base = byte_queue.size() + bytes_sent;
        while (byte_queue.size() + bytes_sent - random_base < 170) begin
            start_packet();
            repeat ($urandom_range(0, 3)) begin
                roll = $urandom_range(0, 9);
                if (roll < 4) begin
                    units = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 3;
                    add_server(units, $urandom, {$urandom, $urandom, $urandom, $urandom});
                end else if (roll < 8) begin
                    random_name();
                    units = (8 + name_text.size() + 7) / 8;
                    if ($urandom_range(0, 7) == 0 && units > 1)
                        units = units - 1;
                    else if ($urandom_range(0, 7) == 0)
                        units = units + 1;
                    add_search(units);
                end else begin
                    add_other(rand_byte(), $urandom_range(1, 4));
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 8)
                add_zero_length();
            if (roll >= 8 && roll < 16)
                send_packet($urandom_range(1, pkt_bytes.size() - 1));
            else
                send_packet(pkt_bytes.size());
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("ra_dns_option_parser verification clean");
        else
            $display("ra_dns_option_parser verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("ra_dns_option_parser verification failed");
        $finish;
    end

endmodule
